// File: rtl/tmas_pkg.sv
`timescale 1ns / 1ps

package tmas_pkg;

  localparam int SMP_W     = 12;
  localparam int CH_W      = 3;
  localparam int SCL_W     = 16;
  localparam int VAL_W     = 16;
  localparam int AVG_W     = 12;
  localparam int PROD_W    = AVG_W + SCL_W;
  localparam int DIV_W     = 14;
  localparam int SEL_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int SCALE_REGS = 4;

  localparam logic [DIV_W-1:0] SCALE_UNIT  = 14'd10000;
  localparam logic [SCL_W-1:0] SCALE_RESET = 16'd10000;

  // 10000 = 16 * 625: shift out 16, then multiply by the reciprocal of 625
  localparam int UNIT_PRE_SH = 4;
  localparam int UNIT_IN_W   = PROD_W - UNIT_PRE_SH;
  localparam int UNIT_RCP_W  = 25;
  localparam int UNIT_SH     = 34;
  localparam int UNIT_PROD_W = UNIT_IN_W + UNIT_RCP_W;
  localparam logic [UNIT_RCP_W-1:0] UNIT_RCP = 25'd27487791;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONFIGURED = 3'd0,
    REG_SCALE_CH0  = 3'd1,
    REG_SCALE_CH1  = 3'd2,
    REG_SCALE_CH2  = 3'd3,
    REG_SCALE_CH3  = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_FILL,
    S_PIV_RD,
    S_PIV_CAP,
    S_SCAN,
    S_ACC,
    S_DIV_A,
    S_MUL,
    S_DIV_B,
    S_PUSH
  } state_e;

endpackage

// File: rtl/trimmed_mean_adc_scaler_top.sv
// Trimmed-mean converter scaler.
// Input channel: one word per accepted cycle (in_valid_i high, in_stall_o low),
// carrying a 12-bit sample and a 3-bit channel index. SAMPLES words form a batch;
// the channel of the final word selects the scale register and is echoed back.
// Output channel: one word per batch (out_valid_o high, out_stall_i low) with the
// scaled trimmed mean and the channel. A stalled result is held in the output
// register while the next batch is loaded; the next result waits until it is taken.
// Config channel: cfg_valid_i/cfg_ready_o, index 0 configured, 1..4 scale_ch0..3;
// cfg_ready_o is always high, writes to other indexes are dropped.
// Throughput: samples load one per cycle. After the final sample the input stalls
// while each pivot scans the single-port sample memory once, then through the states
// for the reciprocal average, the gain multiply, the reciprocal scaling and the push.
// An unconfigured block or an out-of-range channel goes straight to the push with a
// zero result.
// Reset: batch fill restarts, configured clears, every scale returns to 10000.
// The sample memory needs no clearing; each entry is written before it is read.
`timescale 1ns / 1ps

module trimmed_mean_adc_scaler_top #(
  parameter int SAMPLES  = 16,
  parameter int TRIM     = 4,
  parameter int CHANNELS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [tmas_pkg::SMP_W-1:0]      sample_i,
  input  logic [tmas_pkg::CH_W-1:0]       channel_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tmas_pkg::VAL_W-1:0]      value_o,
  output logic [tmas_pkg::CH_W-1:0]       channel_out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tmas_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tmas_pkg::SCL_W-1:0]      cfg_data_i
);

  localparam int IW      = $clog2(SAMPLES);
  localparam int CW      = $clog2(SAMPLES + 1);
  localparam int SW      = tmas_pkg::SMP_W + IW;
  localparam bit NO_KEEP = (2 * TRIM >= SAMPLES);
  localparam int KEPT    = NO_KEEP ? 1 : SAMPLES - 2 * TRIM;
  localparam int KEEP_LO = TRIM;
  localparam int KEEP_HI = SAMPLES - TRIM;
  localparam int AVG_SH  = SW + $clog2(KEPT);
  localparam int RCP_W   = SW + 1;
  localparam int APROD_W = SW + RCP_W;
  localparam logic [RCP_W-1:0] AVG_RCP =
    RCP_W'(((64'd1 << AVG_SH) + 64'(KEPT) - 64'd1) / 64'(KEPT));

  tmas_pkg::state_e state_q, state_d;

  logic [tmas_pkg::SMP_W-1:0] sample_mem [SAMPLES];
  logic [tmas_pkg::SMP_W-1:0] rd_data_q;
  logic [IW-1:0]              rd_addr;
  logic                       wr_en;

  logic [IW-1:0]                 fill_q;
  logic [IW-1:0]                 i_q;
  logic [CW-1:0]                 j_q;
  logic [IW-1:0]                 jd_q;
  logic                          cmp_v_q;
  logic [IW-1:0]                 rank_q;
  logic [tmas_pkg::SMP_W-1:0]    pivot_q;
  logic [SW-1:0]                 sum_q;
  logic [tmas_pkg::PROD_W-1:0]   dvd_q;
  logic [tmas_pkg::CH_W-1:0]     ch_q;
  logic                          zero_q;
  logic                          configured_q;
  logic [tmas_pkg::SCL_W-1:0]    scale_q [tmas_pkg::SCALE_REGS];
  logic                          out_valid_q;
  logic [tmas_pkg::VAL_W-1:0]    value_q;
  logic [tmas_pkg::CH_W-1:0]     chout_q;

  logic                          in_acc;
  logic                          last_smp;
  logic                          skip;
  logic                          issue;
  logic                          less;
  logic                          keep;
  logic [SW-1:0]                 sum_d;
  logic                          last_i;
  logic [APROD_W-1:0]            avg_prod;
  logic [tmas_pkg::UNIT_PROD_W-1:0] unit_prod;
  logic [tmas_pkg::PROD_W-1:0]   prod;
  logic                          out_free;
  logic [tmas_pkg::VAL_W-1:0]    sat;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign last_smp = (fill_q == IW'(SAMPLES - 1));
  assign skip     = (int'(channel_i) >= CHANNELS) || !configured_q || NO_KEEP;
  assign issue    = (j_q != CW'(SAMPLES));
  assign less     = (rd_data_q < pivot_q) || ((rd_data_q == pivot_q) && (jd_q < i_q));
  assign keep     = (int'(rank_q) >= KEEP_LO) && (int'(rank_q) < KEEP_HI);
  assign sum_d    = sum_q + (keep ? SW'(pivot_q) : SW'(0));
  assign last_i   = (i_q == IW'(SAMPLES - 1));
  assign avg_prod = APROD_W'(dvd_q[SW-1:0]) * APROD_W'(AVG_RCP);
  assign unit_prod = tmas_pkg::UNIT_PROD_W'(dvd_q[tmas_pkg::PROD_W-1:tmas_pkg::UNIT_PRE_SH])
                   * tmas_pkg::UNIT_PROD_W'(tmas_pkg::UNIT_RCP);
  assign prod     = tmas_pkg::PROD_W'(dvd_q[tmas_pkg::AVG_W-1:0])
                  * tmas_pkg::PROD_W'(scale_q[ch_q[tmas_pkg::SEL_W-1:0]]);
  assign out_free = !out_valid_q || !out_stall_i;
  assign sat      = (|dvd_q[tmas_pkg::PROD_W-1:tmas_pkg::VAL_W]) ? '1
                                                                 : dvd_q[tmas_pkg::VAL_W-1:0];

  assign out_valid_o   = out_valid_q;
  assign value_o       = value_q;
  assign channel_out_o = chout_q;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tmas_pkg::S_FILL: begin
        if (in_acc && last_smp) begin
          state_d = skip ? tmas_pkg::S_PUSH : tmas_pkg::S_PIV_RD;
        end
      end
      tmas_pkg::S_PIV_RD:  state_d = tmas_pkg::S_PIV_CAP;
      tmas_pkg::S_PIV_CAP: state_d = tmas_pkg::S_SCAN;
      tmas_pkg::S_SCAN: begin
        if (!issue && !cmp_v_q) begin
          state_d = tmas_pkg::S_ACC;
        end
      end
      tmas_pkg::S_ACC: state_d = last_i ? tmas_pkg::S_DIV_A : tmas_pkg::S_PIV_RD;
      tmas_pkg::S_DIV_A: state_d = tmas_pkg::S_MUL;
      tmas_pkg::S_MUL:   state_d = tmas_pkg::S_DIV_B;
      tmas_pkg::S_DIV_B: state_d = tmas_pkg::S_PUSH;
      tmas_pkg::S_PUSH: begin
        if (out_free) begin
          state_d = tmas_pkg::S_FILL;
        end
      end
      default: state_d = tmas_pkg::S_FILL;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    wr_en      = 1'b0;
    rd_addr    = i_q;
    unique case (state_q)
      tmas_pkg::S_FILL: begin
        in_stall_o = 1'b0;
        wr_en      = in_valid_i;
      end
      tmas_pkg::S_SCAN: rd_addr = j_q[IW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tmas_pkg::S_FILL;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
      configured_q <= 1'b0;
      for (int k = 0; k < tmas_pkg::SCALE_REGS; k++) begin
        scale_q[k] <= tmas_pkg::SCALE_RESET;
      end
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        fill_q <= last_smp ? '0 : fill_q + IW'(1);
      end
      if (state_q == tmas_pkg::S_PUSH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          tmas_pkg::REG_CONFIGURED: configured_q <= cfg_data_i[0];
          tmas_pkg::REG_SCALE_CH0, tmas_pkg::REG_SCALE_CH1,
          tmas_pkg::REG_SCALE_CH2, tmas_pkg::REG_SCALE_CH3: begin
            scale_q[tmas_pkg::SEL_W'(cfg_index_i - tmas_pkg::REG_SCALE_CH0)] <= cfg_data_i;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sample_mem[fill_q] <= sample_i;
    end
    rd_data_q <= sample_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      tmas_pkg::S_FILL: begin
        if (in_acc && last_smp) begin
          ch_q   <= channel_i;
          zero_q <= skip;
          sum_q  <= '0;
          i_q    <= '0;
        end
      end
      tmas_pkg::S_PIV_CAP: begin
        pivot_q <= rd_data_q;
        j_q     <= '0;
        cmp_v_q <= 1'b0;
        rank_q  <= '0;
      end
      tmas_pkg::S_SCAN: begin
        if (issue) begin
          j_q <= j_q + CW'(1);
        end
        cmp_v_q <= issue;
        jd_q    <= j_q[IW-1:0];
        if (cmp_v_q && less) begin
          rank_q <= rank_q + IW'(1);
        end
      end
      tmas_pkg::S_ACC: begin
        sum_q <= sum_d;
        i_q   <= i_q + IW'(1);
        if (last_i) begin
          dvd_q <= tmas_pkg::PROD_W'(sum_d);
        end
      end
      tmas_pkg::S_DIV_A: begin
        dvd_q <= tmas_pkg::PROD_W'(avg_prod[AVG_SH +: tmas_pkg::AVG_W]);
      end
      tmas_pkg::S_MUL: begin
        dvd_q <= prod;
      end
      tmas_pkg::S_DIV_B: begin
        dvd_q <= tmas_pkg::PROD_W'(unit_prod[tmas_pkg::UNIT_PROD_W-1:tmas_pkg::UNIT_SH]);
      end
      tmas_pkg::S_PUSH: begin
        if (out_free) begin
          value_q <= zero_q ? '0 : sat;
          chout_q <= ch_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/tmas_checker.sv
`timescale 1ns / 1ps

module tmas_checker #(
  parameter int CHANNELS = 4
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [tmas_pkg::VAL_W-1:0] value_o,
  input logic [tmas_pkg::CH_W-1:0]  channel_out_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(value_o) && $stable(channel_out_o))
    else $error("stalled result changed");

  // drop the value for an unknown channel
  a_bad_ch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (int'(channel_out_o) >= CHANNELS) |-> (value_o == '0))
    else $error("nonzero value for out-of-range channel");

  // results appear only after the input side was held off
  a_push_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised while input was open");

endmodule

bind trimmed_mean_adc_scaler_top tmas_checker #(
  .CHANNELS (CHANNELS)
) u_tmas_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .value_o       (value_o),
  .channel_out_o (channel_out_o)
);

// File: dv/trimmed_mean_adc_scaler_top_tb.sv
`timescale 1ns / 1ps

module trimmed_mean_adc_scaler_top_tb;

  localparam int N_SAMPLES     = 16;
  localparam int N_TRIM        = 4;
  localparam int N_CHANNELS    = 4;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_BATCHES = 3;

  localparam logic [tmas_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [tmas_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
  localparam logic [tmas_pkg::SCL_W-1:0]     GAIN_MAX        = '1;
  localparam logic [tmas_pkg::SMP_W-1:0]     SAMPLE_MAX      = '1;
  localparam logic [tmas_pkg::VAL_W-1:0]     VALUE_MAX       = '1;

  typedef struct packed {
    logic [tmas_pkg::VAL_W-1:0] value;
    logic [tmas_pkg::CH_W-1:0]  channel;
  } scaled_result_t;

  typedef logic [tmas_pkg::SMP_W-1:0] batch_t [N_SAMPLES];

  typedef enum int {
    MIX_UNIFORM,
    MIX_LOW,
    MIX_HIGH,
    MIX_SPIKES,
    MIX_FLAT
  } mix_e;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [tmas_pkg::SMP_W-1:0]     sample_i;
  logic [tmas_pkg::CH_W-1:0]      channel_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [tmas_pkg::VAL_W-1:0]     value_o;
  logic [tmas_pkg::CH_W-1:0]      channel_out_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [tmas_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [tmas_pkg::SCL_W-1:0]     cfg_data_i;

  logic                       enabled_q;
  logic [tmas_pkg::SCL_W-1:0] gain_q [tmas_pkg::SCALE_REGS];
  batch_t                     held_samples;
  int                         held_count;
  scaled_result_t             pending_results [$];

  bit idle_on;
  bit stall_on;
  int mismatch_count;
  int words_sent;
  int batches_sent;
  int reg_writes;
  int results_checked;
  int zero_results;

  trimmed_mean_adc_scaler_top #(
    .SAMPLES (N_SAMPLES),
    .TRIM    (N_TRIM),
    .CHANNELS(N_CHANNELS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .channel_i    (channel_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (value_o),
    .channel_out_o(channel_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [tmas_pkg::SMP_W-1:0] trimmed_average(batch_t s);
    batch_t                     w;
    logic [tmas_pkg::SMP_W-1:0] t;
    int unsigned                acc;
    int                         kept;
    if (2 * N_TRIM >= N_SAMPLES) return '0;
    w = s;
    for (int i = 0; i < N_SAMPLES - 1; i++) begin
      for (int j = 0; j < N_SAMPLES - 1 - i; j++) begin
        if (w[j] > w[j+1]) begin
          t      = w[j];
          w[j]   = w[j+1];
          w[j+1] = t;
        end
      end
    end
    acc  = 0;
    kept = N_SAMPLES - 2 * N_TRIM;
    for (int i = N_TRIM; i < N_SAMPLES - N_TRIM; i++) acc += w[i];
    return tmas_pkg::SMP_W'(acc / kept);
  endfunction

  task automatic predict_sample(logic [tmas_pkg::SMP_W-1:0] smp,
                                logic [tmas_pkg::CH_W-1:0] ch);
    scaled_result_t r;
    longint         scaled;
    held_samples[held_count] = smp;
    held_count++;
    if (held_count == N_SAMPLES) begin
      held_count = 0;
      r.channel  = ch;
      if (ch >= N_CHANNELS || !enabled_q) begin
        r.value = '0;
      end else begin
        scaled  = longint'(trimmed_average(held_samples))
                  * longint'(gain_q[tmas_pkg::SEL_W'(ch)])
                  / longint'(tmas_pkg::SCALE_UNIT);
        r.value = (scaled > longint'(VALUE_MAX)) ? VALUE_MAX : tmas_pkg::VAL_W'(scaled);
      end
      pending_results.push_back(r);
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_sample(logic [tmas_pkg::SMP_W-1:0] smp, logic [tmas_pkg::CH_W-1:0] ch);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    channel_i  <= ch;
    do @(posedge clk_i); while (in_stall_o);
    predict_sample(smp, ch);
    words_sent++;
  endtask

  task automatic send_batch(batch_t s, logic [tmas_pkg::CH_W-1:0] last_ch);
    for (int i = 0; i < N_SAMPLES; i++) begin
      send_sample(s[i], (i == N_SAMPLES - 1) ? last_ch
                                             : tmas_pkg::CH_W'($urandom_range(0, 7)));
    end
    batches_sent++;
  endtask

  function automatic batch_t random_batch();
    batch_t                     s;
    mix_e                       mix;
    logic [tmas_pkg::SMP_W-1:0] level;
    int                         r;
    mix   = mix_e'($urandom_range(0, 4));
    level = tmas_pkg::SMP_W'($urandom);
    for (int i = 0; i < N_SAMPLES; i++) begin
      r = $urandom_range(0, 15);
      case (mix)
        MIX_UNIFORM: s[i] = tmas_pkg::SMP_W'($urandom);
        MIX_LOW:     s[i] = tmas_pkg::SMP_W'($urandom_range(0, 15));
        MIX_HIGH:    s[i] = tmas_pkg::SMP_W'($urandom_range(4080, 4095));
        MIX_SPIKES:  s[i] = (r < 4) ? '0 : (r < 8) ? SAMPLE_MAX : tmas_pkg::SMP_W'($urandom);
        default:     s[i] = level;
      endcase
    end
    return s;
  endfunction

  function automatic logic [tmas_pkg::CH_W-1:0] random_last_channel();
    if ($urandom_range(0, 9) < 8) return tmas_pkg::CH_W'($urandom_range(0, N_CHANNELS - 1));
    return tmas_pkg::CH_W'($urandom_range(N_CHANNELS, 7));
  endfunction

  task automatic hold_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    hold_input();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [tmas_pkg::CFG_IDX_W-1:0] idx,
                           logic [tmas_pkg::SCL_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == tmas_pkg::REG_CONFIGURED) begin
      enabled_q = data[0];
    end else if (idx >= tmas_pkg::REG_SCALE_CH0 && idx <= tmas_pkg::REG_SCALE_CH3) begin
      gain_q[tmas_pkg::SEL_W'(idx - tmas_pkg::REG_SCALE_CH0)] = data;
    end
    reg_writes++;
  endtask

  task automatic release_cfg();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_gains(logic [tmas_pkg::SCL_W-1:0] g0, logic [tmas_pkg::SCL_W-1:0] g1,
                             logic [tmas_pkg::SCL_W-1:0] g2, logic [tmas_pkg::SCL_W-1:0] g3);
    write_reg(tmas_pkg::REG_SCALE_CH0, g0);
    write_reg(tmas_pkg::REG_SCALE_CH1, g1);
    write_reg(tmas_pkg::REG_SCALE_CH2, g2);
    write_reg(tmas_pkg::REG_SCALE_CH3, g3);
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_on && $urandom_range(0, 9) < 3) begin
        out_stall_i <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 250)) @(negedge clk_i);
        else repeat ($urandom_range(1, 3)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    scaled_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %0d channel %0d", value_o, channel_out_o);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (value_o !== exp_r.value) begin
          $error("value: expected %0d, got %0d", exp_r.value, value_o);
          mismatch_count++;
        end
        if (channel_out_o !== exp_r.channel) begin
          $error("channel_out: expected %0d, got %0d", exp_r.channel, channel_out_o);
          mismatch_count++;
        end
        results_checked++;
        if (value_o == '0) zero_results++;
      end
    end
  end

  task automatic test_reset_unconfigured();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    send_batch(random_batch(), tmas_pkg::CH_W'(2));
    drain();
  endtask

  task automatic test_unmapped_index();
    for (int i = REG_UNMAPPED_LO; i <= REG_UNMAPPED_HI; i++) begin
      write_reg(tmas_pkg::CFG_IDX_W'(i), GAIN_MAX);
    end
    write_reg(tmas_pkg::REG_CONFIGURED, 16'd1);
    release_cfg();
    idle_on = 1'b1;
    send_batch(random_batch(), tmas_pkg::CH_W'(1));
    drain();
  endtask

  task automatic test_extremes();
    batch_t s;
    write_gains(GAIN_MAX, '0, tmas_pkg::SCALE_RESET, GAIN_MAX);
    release_cfg();
    stall_on = 1'b1;
    s = '{default: SAMPLE_MAX};
    send_batch(s, tmas_pkg::CH_W'(0));
    send_batch(s, tmas_pkg::CH_W'(1));
    s = '{default: '0};
    send_batch(s, tmas_pkg::CH_W'(3));
    for (int i = 0; i < N_SAMPLES; i++) begin
      case (i % 4)
        0:       s[i] = '0;
        1:       s[i] = SAMPLE_MAX;
        default: s[i] = tmas_pkg::SMP_W'(1000 + 37 * i);
      endcase
    end
    send_batch(s, tmas_pkg::CH_W'(2));
    drain();
  endtask

  task automatic test_bad_channel();
    for (int ch = N_CHANNELS; ch <= 7; ch++) begin
      send_batch(random_batch(), tmas_pkg::CH_W'(ch));
    end
    drain();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(tmas_pkg::REG_CONFIGURED, 16'd1);
          write_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
        end
        1: write_gains('0, '0, '0, '0);
        2: begin
          write_gains(tmas_pkg::SCL_W'($urandom), tmas_pkg::SCL_W'($urandom),
                      tmas_pkg::SCL_W'($urandom), tmas_pkg::SCL_W'($urandom));
          write_reg(tmas_pkg::CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)), '0);
        end
        3: write_reg(tmas_pkg::REG_CONFIGURED, 16'd0);
        default: begin
          write_reg(tmas_pkg::REG_CONFIGURED, 16'd1);
          write_gains(tmas_pkg::SCALE_RESET, 16'd1, tmas_pkg::SCL_W'($urandom),
                      tmas_pkg::SCL_W'($urandom));
        end
      endcase
      release_cfg();
      for (int b = 0; b < PHASE_BATCHES; b++) begin
        idle_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
        send_batch(random_batch(), random_last_channel());
      end
    end
    drain();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    channel_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = tmas_pkg::REG_CONFIGURED;
    cfg_data_i  = '0;
    enabled_q   = 1'b0;
    for (int i = 0; i < tmas_pkg::SCALE_REGS; i++) gain_q[i] = tmas_pkg::SCALE_RESET;
    held_count  = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_unconfigured();
    test_unmapped_index();
    test_extremes();
    test_bad_channel();
    test_random_settings();

    $display("Sent %0d words in %0d batches with %0d register writes across gain settings",
             words_sent, batches_sent, reg_writes);
    $display("Checked %0d results, %0d of them zero", results_checked, zero_results);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
